FILE: rtl/lra_pkg.sv
// ----------------------------------------------------------------------------
// lra_pkg
// Shared types and constants of the line rasterizer: request codes, colour
// type and the back-end status bundle.
// ----------------------------------------------------------------------------
package lra_pkg;

  localparam int unsigned COLOR_BITS = 24;

  typedef logic [COLOR_BITS-1:0] color_t;

  localparam color_t COLOR_RESET = 24'hFF_FFFF;

  // Request codes on the action field.
  typedef enum logic {
    ACT_BEGIN = 1'b0,
    ACT_STEP  = 1'b1
  } action_e;

  // Status of the back end in the current cycle.
  typedef struct packed {
    logic busy;  // a line is in progress
    logic pop;   // a queued request is consumed this cycle
    logic emit;  // a pixel is loaded into the output register this cycle
  } status_t;

endpackage

FILE: rtl/lra_if.sv
// ----------------------------------------------------------------------------
// lra_if
// Channel interfaces of the line rasterizer: requests, pixels and the colour
// register write port.
// ----------------------------------------------------------------------------
interface lra_req_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, action, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, action, x_start, y_start, x_end, y_end, output ready);
endinterface

interface lra_px_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  lra_pkg::color_t       pixel_color;
  logic                  last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

interface lra_cfg_if;
  logic            valid;
  logic            ready;
  lra_pkg::color_t draw_color;

  modport source (output valid, draw_color, input ready);
  modport sink   (input valid, draw_color, output ready);
endinterface

FILE: rtl/line_rasterizer.sv
// ----------------------------------------------------------------------------
// line_rasterizer
// Integer line-drawing engine: one pixel per step request, in draw colour.
// ----------------------------------------------------------------------------
// Usage:
//   req_i   - requests. action ACT_BEGIN loads the endpoints of a new line
//             (a begin while a line is running drops that line); ACT_STEP
//             asks for the next pixel. A step with no line running is
//             consumed and gives nothing.
//   px_o    - pixels: column, row, colour and a flag on the final pixel.
//   cfg_i   - write port of the draw colour; write it only while idle.
// Throughput: one request per clock, begin or step, while px_o is not stalled;
//   the stepping engine sets the pace, with one error add and compare per pixel.
// Path: an accepted step request is written into the queue; when it is
//   popped, its pixel is loaded into the output register, from which the
//   receiver takes it.
// Reset: no line running, queue empty, output invalid, colour white.
// Stall: a pixel held on px_o stalls the engine; requests still fill the
//   two-entry queue, and req_i.ready drops once it is full. Begin requests
//   and idle steps drain even while px_o is stalled.
// ----------------------------------------------------------------------------
module line_rasterizer #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lra_req_if.sink   req_i,
  lra_px_if.source  px_o,
  lra_cfg_if.sink   cfg_i
);

  localparam int unsigned EntryBits  = 2 + 6 * COORD_BITS;
  localparam int unsigned QueueDepth = 2;

  lra_pkg::color_t  color_q;
  lra_pkg::status_t status;

  logic                 push_valid, push_ready;
  logic [EntryBits-1:0] push_data;
  logic                 cmd_valid, cmd_ready;
  logic [EntryBits-1:0] cmd_data;

  // Colour register: always ready, take the write on valid.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= lra_pkg::COLOR_RESET;
    end else if (cfg_i.valid) begin
      color_q <= cfg_i.draw_color;
    end
  end

  // Classify requests and set up begin requests.
  lra_front #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_BITS (EntryBits)
  ) u_front (
    .req          (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decouple the classifier from the stepping engine.
  lra_queue #(
    .WIDTH (EntryBits),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (cmd_valid),
    .pop_ready_i  (cmd_ready),
    .pop_data_o   (cmd_data)
  );

  // Walk the line and drive the pixel register.
  lra_back #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_BITS (EntryBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_data_i   (cmd_data),
    .draw_color_i (color_q),
    .px           (px_o),
    .status_o     (status)
  );

  // A pixel comes only from a consumed request while a line runs.
  a_emit_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.emit |-> (status.busy && status.pop))
    else $error("pixel emitted without a running line");

  // Never overwrite a pixel the receiver has not taken.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (px_o.valid && !px_o.ready) |-> !status.emit)
    else $error("stalled pixel overwritten");

  // The final pixel ends the line, and only the final pixel does.
  a_last_ends_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.emit |=> (px_o.valid && (px_o.last_pixel == !status.busy)))
    else $error("last_pixel disagrees with line state");

endmodule

FILE: rtl/lra_front.sv
// ----------------------------------------------------------------------------
// lra_front
// Request classifier: tags step requests and, for begin requests, computes
// the spans, the steep flag and the major/minor view of both endpoints.
// ----------------------------------------------------------------------------
module lra_front #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned ENTRY_BITS = 2 + 6 * COORD_BITS
) (
  lra_req_if.sink               req,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output logic [ENTRY_BITS-1:0] push_data_o
);

  logic                  is_step;
  logic                  steep;
  logic [COORD_BITS-1:0] dx, dy;
  logic [COORD_BITS-1:0] ma, na, mb, nb;
  logic [COORD_BITS-1:0] d_major, d_minor;

  always_comb begin
    is_step = (req.action == lra_pkg::ACT_STEP);
    dx = (req.x_start > req.x_end) ? (req.x_start - req.x_end) : (req.x_end - req.x_start);
    dy = (req.y_start > req.y_end) ? (req.y_start - req.y_end) : (req.y_end - req.y_start);
    // Ties stay on the x axis.
    steep = (dy > dx);
    if (steep) begin
      ma      = req.y_start;
      na      = req.x_start;
      mb      = req.y_end;
      nb      = req.x_end;
      d_major = dy;
      d_minor = dx;
    end else begin
      ma      = req.x_start;
      na      = req.y_start;
      mb      = req.x_end;
      nb      = req.y_end;
      d_major = dx;
      d_minor = dy;
    end
  end

  assign push_data_o  = {is_step, steep, ma, na, mb, nb, d_major, d_minor};
  assign push_valid_o = req.valid;
  assign req.ready    = push_ready_i;

endmodule

FILE: rtl/lra_queue.sv
// ----------------------------------------------------------------------------
// lra_queue
// Short register FIFO between the classifier and the stepping engine.
// ----------------------------------------------------------------------------
module lra_queue #(
  parameter int unsigned WIDTH = 74,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrBits = $clog2(DEPTH);
  localparam int unsigned CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] PtrLast = PtrBits'(DEPTH - 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(DEPTH);

  logic [WIDTH-1:0]   mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != CntFull);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/lra_back.sv
// ----------------------------------------------------------------------------
// lra_back
// Stepping engine: loads a line on a begin request; while a line runs, emits
// one pixel per step request into the output register and advances the error terms.
// ----------------------------------------------------------------------------
module lra_back #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned ENTRY_BITS = 2 + 6 * COORD_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  logic [ENTRY_BITS-1:0] cmd_data_i,
  input  lra_pkg::color_t       draw_color_i,
  lra_px_if.source              px,
  output lra_pkg::status_t      status_o
);

  localparam int unsigned ErrBits = 2 * COORD_BITS + 2;

  logic                  e_step, e_steep;
  logic [COORD_BITS-1:0] e_ma, e_na, e_mb, e_nb, e_dmaj, e_dmin;

  logic                  busy_q, busy_d;
  logic                  px_valid_q, px_valid_d;
  logic                  steep_q, minor_up_q;
  logic [COORD_BITS-1:0] major_pos_q, major_end_q, minor_pos_q;
  logic [COORD_BITS-1:0] d_major_q, d_minor_q;
  logic [ErrBits-1:0]    err_off_q, err_thr_q;
  logic [COORD_BITS-1:0] px_x_q, px_y_q;
  lra_pkg::color_t       px_color_q;
  logic                  px_last_q;

  logic               slot_free, pop, load, emit, swap, is_last, minor_move;
  logic [ErrBits-1:0] off_sum;

  assign {e_step, e_steep, e_ma, e_na, e_mb, e_nb, e_dmaj, e_dmin} = cmd_data_i;

  always_comb begin
    slot_free   = !px_valid_q || px.ready;
    // Begin and idle steps never touch the output.
    cmd_ready_o = !e_step || !busy_q || slot_free;
    pop         = cmd_valid_i && cmd_ready_o;
    load        = pop && !e_step;
    emit        = pop && e_step && busy_q;
    swap        = (e_ma > e_mb);
    is_last     = (major_pos_q == major_end_q);
    off_sum     = err_off_q + ErrBits'({d_minor_q, 1'b0});
    minor_move  = (off_sum >= err_thr_q);

    busy_d = busy_q;
    if (load) begin
      busy_d = 1'b1;
    end else if (emit && is_last) begin
      busy_d = 1'b0;
    end

    px_valid_d = px_valid_q;
    if (emit) begin
      px_valid_d = 1'b1;
    end else if (px.ready) begin
      px_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      px_valid_q <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      px_valid_q <= px_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      steep_q     <= e_steep;
      major_pos_q <= swap ? e_mb : e_ma;
      major_end_q <= swap ? e_ma : e_mb;
      minor_pos_q <= swap ? e_nb : e_na;
      minor_up_q  <= swap ? (e_nb < e_na) : (e_na < e_nb);
      d_major_q   <= e_dmaj;
      d_minor_q   <= e_dmin;
      err_off_q   <= '0;
      err_thr_q   <= ErrBits'(e_dmaj);
    end else if (emit) begin
      err_off_q   <= off_sum;
      major_pos_q <= major_pos_q + 1'b1;
      if (minor_move) begin
        minor_pos_q <= minor_up_q ? (minor_pos_q + 1'b1) : (minor_pos_q - 1'b1);
        err_thr_q   <= err_thr_q + ErrBits'({d_major_q, 1'b0});
      end
    end
    if (emit) begin
      px_x_q     <= steep_q ? minor_pos_q : major_pos_q;
      px_y_q     <= steep_q ? major_pos_q : minor_pos_q;
      px_color_q <= draw_color_i;
      px_last_q  <= is_last;
    end
  end

  assign px.valid       = px_valid_q;
  assign px.pixel_x     = px_x_q;
  assign px.pixel_y     = px_y_q;
  assign px.pixel_color = px_color_q;
  assign px.last_pixel  = px_last_q;

  assign status_o.busy = busy_q;
  assign status_o.pop  = pop;
  assign status_o.emit = emit;

endmodule
